// File: design/rwalu_pkg.sv
// ----------------------------------------------------------------------------
// rwalu_pkg
// Shared widths, operation codes, status codes and register indexes of the
// range wrapping integer ALU.
// ----------------------------------------------------------------------------
package rwalu_pkg;

    localparam int VALUE_WIDTH   = 16;
    localparam int OPERAND_WIDTH = 32;
    localparam int MODE_W        = 5;
    localparam int STATUS_W      = 2;
    localparam int CFG_INDEX_W   = 2;

    localparam int RANGE_LOW_RESET  = 0;
    localparam int RANGE_HIGH_RESET = 255;

    localparam logic [CFG_INDEX_W-1:0] REG_RANGE_LOW  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_RANGE_HIGH = 2'd1;

    localparam logic [MODE_W-1:0] MODE_ASSIGN  = 5'd0;
    localparam logic [MODE_W-1:0] MODE_ADD     = 5'd1;
    localparam logic [MODE_W-1:0] MODE_SUB     = 5'd2;
    localparam logic [MODE_W-1:0] MODE_RSUB    = 5'd3;
    localparam logic [MODE_W-1:0] MODE_MIRROR  = 5'd4;
    localparam logic [MODE_W-1:0] MODE_MUL     = 5'd5;
    localparam logic [MODE_W-1:0] MODE_DIV     = 5'd6;
    localparam logic [MODE_W-1:0] MODE_RDIV    = 5'd7;
    localparam logic [MODE_W-1:0] MODE_MOD     = 5'd8;
    localparam logic [MODE_W-1:0] MODE_RMOD    = 5'd9;
    localparam logic [MODE_W-1:0] MODE_AND     = 5'd10;
    localparam logic [MODE_W-1:0] MODE_OR      = 5'd11;
    localparam logic [MODE_W-1:0] MODE_XOR     = 5'd12;
    localparam logic [MODE_W-1:0] MODE_NOT     = 5'd13;
    localparam logic [MODE_W-1:0] MODE_SHL     = 5'd14;
    localparam logic [MODE_W-1:0] MODE_SHR     = 5'd15;
    localparam logic [MODE_W-1:0] MODE_RSHL    = 5'd16;
    localparam logic [MODE_W-1:0] MODE_RSHR    = 5'd17;
    localparam logic [MODE_W-1:0] MODE_COMPARE = 5'd18;

    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_DIV_ZERO  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NOT_EXACT = 2'd2;
    localparam logic [STATUS_W-1:0] ST_BAD_RANGE = 2'd3;

endpackage

// File: design/rwalu_div.sv
// ----------------------------------------------------------------------------
// rwalu_div
// Bit-serial restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module rwalu_div #(
    parameter int DIVIDEND_W = 64,
    parameter int DIVISOR_W  = 33
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  start,
    input  logic [DIVIDEND_W-1:0] dividend,
    input  logic [DIVISOR_W-1:0]  divisor,
    output logic                  busy,
    output logic                  done,
    output logic [DIVIDEND_W-1:0] quotient,
    output logic [DIVISOR_W-1:0]  remainder
);

    localparam int CW = $clog2(DIVIDEND_W + 1);

    logic                  busy_reg;
    logic                  done_reg;
    logic [CW-1:0]         cnt_reg;
    logic [DIVIDEND_W-1:0] quo_reg;
    logic [DIVISOR_W-1:0]  rem_reg;
    logic [DIVISOR_W-1:0]  dvs_reg;

    logic [DIVISOR_W:0] trial;
    logic [DIVISOR_W:0] diff;
    logic               ge;

    assign trial = {rem_reg, quo_reg[DIVIDEND_W-1]};
    assign ge    = trial >= {1'b0, dvs_reg};
    assign diff  = trial - {1'b0, dvs_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                quo_reg  <= dividend;
                rem_reg  <= '0;
                dvs_reg  <= divisor;
                cnt_reg  <= CW'(DIVIDEND_W);
                busy_reg <= 1'b1;
            end else if (busy_reg) begin
                rem_reg <= ge ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
                quo_reg <= {quo_reg[DIVIDEND_W-2:0], ge};
                cnt_reg <= cnt_reg - CW'(1);
                if (cnt_reg == CW'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign busy      = busy_reg;
    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

// File: design/range_wrapping_integer_alu.sv
// ----------------------------------------------------------------------------
// range_wrapping_integer_alu
// Accumulator ALU whose results are wrapped into a configured range.
// ----------------------------------------------------------------------------
// One beat is worked on at a time. With W = max(VALUE_WIDTH, OPERAND_WIDTH)
// + 32 (64 at the defaults) as the dividend width of the single bit-serial
// divider, which produces one quotient bit per cycle, the divide and remainder
// modes use the divider first for the divide itself and then for the reduction
// into the range; the other modes use it only for the reduction. Divide-by-zero,
// bad-range and compare beats skip the divider, and an exact divide with a
// remainder or with no quotient in range skips the reduction. The result sits in
// an output register, so a new beat is taken while it waits.
module range_wrapping_integer_alu #(
    parameter int VALUE_WIDTH   = rwalu_pkg::VALUE_WIDTH,
    parameter int OPERAND_WIDTH = rwalu_pkg::OPERAND_WIDTH
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_wr_en,
    input  logic [rwalu_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [VALUE_WIDTH-1:0]              cfg_data,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [rwalu_pkg::MODE_W-1:0]        s_mode,
    input  logic signed [OPERAND_WIDTH-1:0]     s_operand,
    input  logic                                s_write_back,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic signed [VALUE_WIDTH-1:0]       m_result,
    output logic signed [VALUE_WIDTH-1:0]       m_prior_value,
    output logic [rwalu_pkg::STATUS_W-1:0]      m_status,
    output logic                                m_is_equal,
    output logic                                m_is_greater,
    output logic                                m_is_less
);

    localparam int VW = VALUE_WIDTH;
    localparam int OW = OPERAND_WIDTH;
    localparam int MW = (VW > OW) ? VW : OW;
    localparam int RW = MW + 32;
    localparam int DW = RW;
    localparam int DV = MW + 1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PREP,
        S_DIVW,
        S_RED,
        S_REDW,
        S_FIN
    } state_t;

    state_t                           state_reg;
    logic signed [VW-1:0]             acc_reg;
    logic signed [VW-1:0]             lo_reg;
    logic signed [VW-1:0]             hi_reg;
    logic [rwalu_pkg::MODE_W-1:0]     mode_reg;
    logic signed [OW-1:0]             x_reg;
    logic                             wb_reg;
    logic signed [VW-1:0]             a_reg;
    logic signed [RW-1:0]             raw_reg;
    logic [rwalu_pkg::STATUS_W-1:0]   status_reg;
    logic signed [VW-1:0]             res_reg;
    logic                             tneg_reg;
    logic                             dd_neg_reg;
    logic                             dv_neg_reg;
    logic                             m_valid_reg;
    logic signed [VW-1:0]             m_result_reg;
    logic signed [VW-1:0]             m_prior_reg;
    logic [rwalu_pkg::STATUS_W-1:0]   m_status_reg;
    logic                             m_eq_reg;
    logic                             m_gt_reg;
    logic                             m_lt_reg;

    logic signed [RW-1:0]    a_ext;
    logic signed [RW-1:0]    x_ext;
    logic signed [RW-1:0]    lo_ext;
    logic signed [RW-1:0]    hi_ext;
    logic signed [VW+OW-1:0] prod;
    logic signed [RW-1:0]    raw_calc;
    logic signed [VW+1:0]    span;
    logic [VW:0]             modv;
    logic                    bad_range;
    logic                    is_div_mode;
    logic                    div_zero;
    logic signed [RW-1:0]    dd_ext;
    logic signed [RW-1:0]    dv_ext;
    logic [RW-1:0]           dd_abs;
    logic [RW-1:0]           dv_abs;
    logic signed [RW-1:0]    t_val;
    logic [RW-1:0]           t_abs;
    logic signed [RW-1:0]    q_val;
    logic signed [RW-1:0]    r_val;
    logic [VW:0]             rem_lo;
    logic [VW:0]             rr;
    logic                    out_free;

    logic                    div_start;
    logic [DW-1:0]           div_dividend;
    logic [DV-1:0]           div_divisor;
    logic                    div_busy;
    logic                    div_done;
    logic [DW-1:0]           div_quo;
    logic [DV-1:0]           div_rem;

    assign a_ext  = {{(RW-VW){a_reg[VW-1]}}, a_reg};
    assign x_ext  = {{(RW-OW){x_reg[OW-1]}}, x_reg};
    assign lo_ext = {{(RW-VW){lo_reg[VW-1]}}, lo_reg};
    assign hi_ext = {{(RW-VW){hi_reg[VW-1]}}, hi_reg};
    assign prod   = a_reg * x_reg;

    assign span = {{2{hi_reg[VW-1]}}, hi_reg} - {{2{lo_reg[VW-1]}}, lo_reg}
                  + (VW+2)'(1);
    assign modv = span[VW:0];

    assign bad_range   = lo_reg >= hi_reg;
    assign is_div_mode = (mode_reg == rwalu_pkg::MODE_DIV) || (mode_reg == rwalu_pkg::MODE_RDIV)
                      || (mode_reg == rwalu_pkg::MODE_MOD) || (mode_reg == rwalu_pkg::MODE_RMOD);

    always_comb begin
        case (mode_reg) inside
            rwalu_pkg::MODE_RDIV, rwalu_pkg::MODE_RMOD: begin
                dd_ext = x_ext;
                dv_ext = a_ext;
            end
            default: begin
                dd_ext = a_ext;
                dv_ext = x_ext;
            end
        endcase
    end

    assign div_zero = dv_ext == '0;
    assign dd_abs   = dd_ext[RW-1] ? RW'(-dd_ext) : RW'(dd_ext);
    assign dv_abs   = dv_ext[RW-1] ? RW'(-dv_ext) : RW'(dv_ext);

    always_comb begin
        unique case (mode_reg)
            rwalu_pkg::MODE_ASSIGN: raw_calc = x_ext;
            rwalu_pkg::MODE_ADD:    raw_calc = a_ext + x_ext;
            rwalu_pkg::MODE_SUB:    raw_calc = a_ext - x_ext;
            rwalu_pkg::MODE_RSUB:   raw_calc = x_ext - a_ext;
            rwalu_pkg::MODE_MIRROR: raw_calc = hi_ext + lo_ext - RW'(1) - a_ext;
            rwalu_pkg::MODE_MUL:    raw_calc = RW'(prod);
            rwalu_pkg::MODE_AND:    raw_calc = a_ext & x_ext;
            rwalu_pkg::MODE_OR:     raw_calc = a_ext | x_ext;
            rwalu_pkg::MODE_XOR:    raw_calc = a_ext ^ x_ext;
            rwalu_pkg::MODE_NOT:    raw_calc = ~a_ext;
            rwalu_pkg::MODE_SHL:    raw_calc = a_ext <<< x_reg[4:0];
            rwalu_pkg::MODE_SHR:    raw_calc = a_ext >>> x_reg[4:0];
            rwalu_pkg::MODE_RSHL:   raw_calc = x_ext <<< a_ext[4:0];
            rwalu_pkg::MODE_RSHR:   raw_calc = x_ext >>> a_ext[4:0];
            default:                raw_calc = a_ext;
        endcase
    end

    assign t_val = raw_reg - lo_ext;
    assign t_abs = t_val[RW-1] ? RW'(-t_val) : RW'(t_val);

    assign q_val = (dd_neg_reg ^ dv_neg_reg) ? -$signed(div_quo) : $signed(div_quo);
    assign r_val = dd_neg_reg ? -$signed(RW'(div_rem)) : $signed(RW'(div_rem));

    assign rem_lo = div_rem[VW:0];
    assign rr     = (tneg_reg && rem_lo != '0) ? modv - rem_lo : rem_lo;

    assign div_start    = ((state_reg == S_PREP) && !bad_range && is_div_mode && !div_zero)
                       || (state_reg == S_RED);
    assign div_dividend = (state_reg == S_RED) ? t_abs : dd_abs;
    assign div_divisor  = (state_reg == S_RED) ? DV'(modv) : dv_abs[DV-1:0];

    assign out_free = !m_valid_reg || m_ready;

    rwalu_div #(
        .DIVIDEND_W (DW),
        .DIVISOR_W  (DV)
    ) u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (div_start),
        .dividend  (div_dividend),
        .divisor   (div_divisor),
        .busy      (div_busy),
        .done      (div_done),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            acc_reg     <= VW'(rwalu_pkg::RANGE_LOW_RESET);
            lo_reg      <= VW'(rwalu_pkg::RANGE_LOW_RESET);
            hi_reg      <= VW'(rwalu_pkg::RANGE_HIGH_RESET);
            m_valid_reg <= 1'b0;
        end else begin
            if (m_valid_reg && m_ready && state_reg != S_FIN) begin
                m_valid_reg <= 1'b0;
            end
            if (cfg_wr_en) begin
                unique case (cfg_index)
                    rwalu_pkg::REG_RANGE_LOW:  lo_reg <= cfg_data;
                    rwalu_pkg::REG_RANGE_HIGH: hi_reg <= cfg_data;
                    default: ;
                endcase
            end
            unique case (state_reg)
                S_IDLE: begin
                    if (s_valid) begin
                        mode_reg  <= s_mode;
                        x_reg     <= s_operand;
                        wb_reg    <= s_write_back;
                        a_reg     <= acc_reg;
                        state_reg <= S_PREP;
                    end
                end
                S_PREP: begin
                    res_reg    <= a_reg;
                    status_reg <= rwalu_pkg::ST_OK;
                    dd_neg_reg <= dd_ext[RW-1];
                    dv_neg_reg <= dv_ext[RW-1];
                    raw_reg    <= raw_calc;
                    if (bad_range) begin
                        status_reg <= rwalu_pkg::ST_BAD_RANGE;
                        state_reg  <= S_FIN;
                    end else if (mode_reg > rwalu_pkg::MODE_RSHR) begin
                        state_reg <= S_FIN;
                    end else if (is_div_mode) begin
                        if (div_zero) begin
                            status_reg <= rwalu_pkg::ST_DIV_ZERO;
                            state_reg  <= S_FIN;
                        end else begin
                            state_reg <= S_DIVW;
                        end
                    end else begin
                        state_reg <= S_RED;
                    end
                end
                S_DIVW: begin
                    if (div_done) begin
                        case (mode_reg)
                            rwalu_pkg::MODE_DIV: begin
                                raw_reg <= q_val;
                                if (div_rem != '0 || q_val < lo_ext || q_val > hi_ext) begin
                                    status_reg <= rwalu_pkg::ST_NOT_EXACT;
                                    state_reg  <= S_FIN;
                                end else begin
                                    state_reg <= S_RED;
                                end
                            end
                            rwalu_pkg::MODE_RDIV: begin
                                raw_reg   <= q_val;
                                state_reg <= S_RED;
                            end
                            default: begin
                                raw_reg   <= r_val;
                                state_reg <= S_RED;
                            end
                        endcase
                    end
                end
                S_RED: begin
                    tneg_reg  <= t_val[RW-1];
                    state_reg <= S_REDW;
                end
                S_REDW: begin
                    if (div_done) begin
                        res_reg   <= lo_reg + rr[VW-1:0];
                        state_reg <= S_FIN;
                    end
                end
                S_FIN: begin
                    if (out_free) begin
                        m_valid_reg  <= 1'b1;
                        m_result_reg <= res_reg;
                        m_prior_reg  <= a_reg;
                        m_status_reg <= status_reg;
                        m_eq_reg     <= a_ext == x_ext;
                        m_gt_reg     <= a_ext > x_ext;
                        m_lt_reg     <= a_ext < x_ext;
                        if (status_reg == rwalu_pkg::ST_OK && wb_reg
                            && mode_reg <= rwalu_pkg::MODE_RSHR) begin
                            acc_reg <= res_reg;
                        end
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign s_ready       = state_reg == S_IDLE;
    assign m_valid       = m_valid_reg;
    assign m_result      = m_result_reg;
    assign m_prior_value = m_prior_reg;
    assign m_status      = m_status_reg;
    assign m_is_equal    = m_eq_reg;
    assign m_is_greater  = m_gt_reg;
    assign m_is_less     = m_lt_reg;

`ifndef NO_ASSERTIONS
    // accumulator only moves when a beat completes
    assert property (@(posedge aclk) disable iff (!aresetn)
        !$stable(acc_reg) |-> $past(state_reg) == S_FIN)
        else $error("accumulator changed outside completion");

    // any error status returns the accumulator unchanged
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status != rwalu_pkg::ST_OK |-> m_result == m_prior_value)
        else $error("error beat with modified result");

    // divider is never restarted while running
    assert property (@(posedge aclk) disable iff (!aresetn)
        div_start |-> !div_busy)
        else $error("divider started while busy");
`endif

endmodule
